// File: hw/rtl/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Shared types and constants for the run-length-coded pixel decoder.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

   // Width of the image pixel counters (16 to 32)
   localparam int unsigned COUNT_WIDTH = 32;

   localparam logic [7:0] COUNT_FIELD_MASK = 8'h7f;
   localparam logic [7:0] RUN_FLAG_MASK    = 8'h80;
   localparam logic [7:0] ALPHA_OPAQUE     = 8'hFF;

   typedef enum logic [1:0] {
      DEPTH_16  = 2'd0,
      DEPTH_24  = 2'd1,
      DEPTH_32  = 2'd2,
      DEPTH_BAD = 2'd3
   } depth_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_DEPTH = 2'd2,
      STATUS_RSVD  = 2'd3
   } status_type;

   typedef enum logic {
      CSR_PIXEL_DEPTH  = 1'b0,
      CSR_IMAGE_PIXELS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_item_type;

   typedef struct packed {
      logic        pixel_valid;
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic        image_done;
      logic [1:0]  status;
   } rsp_item_type;

endpackage

// File: hw/rtl/tga_rle_core.sv
// ----------------------------------------------------------------------------
// tga_rle_core
// Configuration registers, packet/pixel state and the one-pass byte decode.
// ----------------------------------------------------------------------------
module tga_rle_core import tga_rle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wdata,
   input  logic          accept,
   input  req_item_type  item,
   output logic          res_valid,
   output rsp_item_type  res_item
);

   depth_type              depth_ff, depth_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;

   logic                   in_packet_ff, in_packet_in;
   logic                   is_run_ff, is_run_in;
   logic [7:0]             left_ff, left_in;
   logic [1:0]             bip_ff, bip_in;
   logic [31:0]            acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0] emitted_ff, emitted_in;
   logic                   finished_ff, finished_in;

   always_comb begin
      depth_in = depth_ff;
      total_in = total_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PIXEL_DEPTH:  depth_in = depth_type'(csr_wdata[1:0]);
            CSR_IMAGE_PIXELS: total_in = csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [COUNT_WIDTH-1:0] owed;
      logic [COUNT_WIDTH-1:0] sum;
      logic [7:0]             count;
      logic [7:0]             repeat_n;
      logic [31:0]            acc_new;
      logic [2:0]             bpp;
      logic [31:0]            value;
      logic                   pix;
      logic                   done;

      in_packet_in = in_packet_ff;
      is_run_in    = is_run_ff;
      left_in      = left_ff;
      bip_in       = bip_ff;
      acc_in       = acc_ff;
      emitted_in   = emitted_ff;
      finished_in  = finished_ff;
      res_valid    = 1'b0;
      res_item     = '0;

      owed     = total_ff - emitted_ff;
      count    = (item.data_byte & COUNT_FIELD_MASK) + 8'd1;
      bpp      = {1'b0, depth_ff} + 3'd2;
      acc_new  = acc_ff;
      for (int i = 0; i < 4; i++) begin
         if (bip_ff == 2'(i))
            acc_new[8*i +: 8] = acc_ff[8*i +: 8] | item.data_byte;
      end
      pix      = in_packet_ff && ({1'b0, bip_ff} + 3'd1 >= bpp);
      repeat_n = is_run_ff ? left_ff : 8'd1;
      sum      = emitted_ff + COUNT_WIDTH'(repeat_n);
      done     = pix && (sum >= total_ff);

      case (depth_ff)
         DEPTH_16: value = {16'h0000, acc_new[15:0]};
         DEPTH_24: value = {ALPHA_OPAQUE, acc_new[23:0]};
         default:  value = acc_new;
      endcase

      if (accept && !finished_ff) begin
         if (depth_ff == DEPTH_BAD) begin
            finished_in     = 1'b1;
            res_valid       = 1'b1;
            res_item.status = STATUS_DEPTH;
         end else if (emitted_ff >= total_ff) begin
            finished_in         = 1'b1;
            res_valid           = 1'b1;
            res_item.image_done = 1'b1;
            res_item.status     = STATUS_OK;
         end else begin
            if (!in_packet_ff) begin
               // clamp the packet to the pixels still owed
               if (owed < COUNT_WIDTH'(count))
                  left_in = owed[7:0];
               else
                  left_in = count;
               is_run_in    = (item.data_byte & RUN_FLAG_MASK) != 8'h00;
               bip_in       = 2'd0;
               acc_in       = '0;
               in_packet_in = 1'b1;
            end else if (pix) begin
               left_in      = is_run_ff ? 8'd0 : left_ff - 8'd1;
               in_packet_in = is_run_ff ? 1'b0 : (left_ff != 8'd1);
               emitted_in   = sum;
               bip_in       = 2'd0;
               acc_in       = '0;
            end else begin
               bip_in = bip_ff + 2'd1;
               acc_in = acc_new;
            end

            if (pix) begin
               res_item.pixel_valid  = 1'b1;
               res_item.pixel_value  = value;
               res_item.repeat_count = repeat_n;
            end
            if (done) begin
               finished_in         = 1'b1;
               res_valid           = 1'b1;
               res_item.image_done = 1'b1;
               res_item.status     = STATUS_OK;
            end else if (item.end_of_data) begin
               finished_in     = 1'b1;
               res_valid       = 1'b1;
               res_item.status = STATUS_SHORT;
            end else begin
               res_valid = pix;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= DEPTH_24;
         total_ff     <= '0;
         in_packet_ff <= 1'b0;
         is_run_ff    <= 1'b0;
         left_ff      <= '0;
         bip_ff       <= '0;
         acc_ff       <= '0;
         emitted_ff   <= '0;
         finished_ff  <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         total_ff     <= total_in;
         in_packet_ff <= in_packet_in;
         is_run_ff    <= is_run_in;
         left_ff      <= left_in;
         bip_ff       <= bip_in;
         acc_ff       <= acc_in;
         emitted_ff   <= emitted_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

// File: hw/rtl/tga_rle_out_buf.sv
// ----------------------------------------------------------------------------
// tga_rle_out_buf
// Result register with a skid stage; stalls the input only when both are full.
// ----------------------------------------------------------------------------
module tga_rle_out_buf import tga_rle_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  rsp_item_type in_item,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_item_ff, main_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         slot_free;

   assign slot_free = !main_valid_ff || !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_item_in  = main_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (slot_free) begin
         if (skid_valid_ff) begin
            // drain the skid stage first
            main_valid_in = 1'b1;
            main_item_in  = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_item_in  = in_item;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_item_ff <= main_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_item  = main_item_ff;

endmodule

// File: hw/rtl/tga_rle_pixel_decoder_unit.sv
// Each result passes through the result register, or through the skid stage first while rsp_stall holds it.
// Throughput: one byte per cycle while req_stall is low; the decode state updates in a single pass per byte.
// The input stalls only when the result register and its skid stage are both full.
// Reset (synchronous): decoder state cleared, depth set to 24-bit, pixel count set to 0.
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// Decodes a run-length-coded true-colour pixel byte stream into pixel results.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit import tga_rle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_item_type  req_item,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_item,
   input  logic          csr_write,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wdata
);

   logic         accept;
   logic         res_valid;
   rsp_item_type res_item;
   logic         buf_full;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   tga_rle_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .item      (req_item),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   tga_rle_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_item   (res_item),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// File: tb/tga_rle_decode_checker.sv
// ----------------------------------------------------------------------------
// tga_rle_decode_checker
// Watches the byte, pixel and register ports of the RLE pixel decoder. Keeps
// its own copy of the decode state, predicts the pixel results of each
// accepted byte, and compares every delivered result with the oldest one
// still owed.
// ----------------------------------------------------------------------------
module tga_rle_decode_checker import tga_rle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  req_item_type  req_item,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  rsp_item_type  rsp_item,
   input  logic          csr_write,
   input  csr_index_type csr_index,
   input  logic [31:0]   csr_wdata,
   output int            error_count,
   output int            pending_results,
   output int            results_seen,
   output logic [31:0]   pixels_decoded
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] COUNT_MASK = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

   rsp_item_type expected_pixels[$];

   depth_type   depth_reg;
   logic [31:0] pixel_total_reg;
   logic        in_packet;
   logic        run_packet;
   logic [7:0]  pixels_left;
   logic [1:0]  byte_idx;
   logic [31:0] accum;
   logic [31:0] emitted;
   logic        finished;
   int          mismatches = 0;
   int          checked = 0;

   task automatic decode_byte(input req_item_type item);
      rsp_item_type res;
      logic [31:0]  total;
      logic [31:0]  owed;
      logic [31:0]  count;
      res = '0;
      total = pixel_total_reg & COUNT_MASK;
      if (finished) return;
      if (depth_reg == DEPTH_BAD) begin
         finished = 1'b1;
         res.status = STATUS_DEPTH;
         expected_pixels.push_back(res);
         return;
      end
      // nothing left to decode: close the image without a pixel
      if (emitted >= total) begin
         finished = 1'b1;
         res.image_done = 1'b1;
         res.status = STATUS_OK;
         expected_pixels.push_back(res);
         return;
      end
      if (!in_packet) begin
         count = {24'd0, item.data_byte & COUNT_FIELD_MASK} + 32'd1;
         owed = total - emitted;
         if (count > owed) count = owed;
         run_packet = (item.data_byte & RUN_FLAG_MASK) != 8'd0;
         pixels_left = count[7:0];
         byte_idx = 2'd0;
         accum = '0;
         in_packet = 1'b1;
      end else begin
         accum |= {24'd0, item.data_byte} << (8 * byte_idx);
         // a depth change mid-pixel completes on reaching or passing the new size
         if (int'(byte_idx) + 1 >= int'(depth_reg) + 2) begin
            case (depth_reg)
               DEPTH_16: res.pixel_value = {16'd0, accum[15:0]};
               DEPTH_24: res.pixel_value = {ALPHA_OPAQUE, accum[23:0]};
               default:  res.pixel_value = accum;
            endcase
            res.pixel_valid = 1'b1;
            if (run_packet) begin
               res.repeat_count = pixels_left;
               pixels_left = 8'd0;
            end else begin
               res.repeat_count = 8'd1;
               pixels_left = pixels_left - 8'd1;
            end
            emitted = (emitted + {24'd0, res.repeat_count}) & COUNT_MASK;
            if (pixels_left == 8'd0) in_packet = 1'b0;
            byte_idx = 2'd0;
            accum = '0;
         end else begin
            byte_idx = byte_idx + 2'd1;
         end
      end
      if (res.pixel_valid && emitted >= total) begin
         finished = 1'b1;
         res.image_done = 1'b1;
         expected_pixels.push_back(res);
      end else if (item.end_of_data) begin
         finished = 1'b1;
         res.status = STATUS_SHORT;
         expected_pixels.push_back(res);
      end else if (res.pixel_valid) begin
         expected_pixels.push_back(res);
      end
   endtask

   task automatic check_pixel(input rsp_item_type got);
      rsp_item_type want;
      checked++;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("checker: unexpected result valid=%0b value=%h repeat=%0d done=%0b status=%0d",
                     got.pixel_valid, got.pixel_value, got.repeat_count, got.image_done,
                     got.status);
         return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_valid !== want.pixel_valid || got.pixel_value !== want.pixel_value ||
          got.repeat_count !== want.repeat_count || got.image_done !== want.image_done ||
          got.status !== want.status) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("checker: result mismatch at %0t", $realtime);
            $display("   expected valid=%0b value=%h repeat=%0d done=%0b status=%0d",
                     want.pixel_valid, want.pixel_value, want.repeat_count, want.image_done,
                     want.status);
            $display("   actual   valid=%0b value=%h repeat=%0d done=%0b status=%0d",
                     got.pixel_valid, got.pixel_value, got.repeat_count, got.image_done,
                     got.status);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         depth_reg = DEPTH_24;
         pixel_total_reg = '0;
         in_packet = 1'b0;
         run_packet = 1'b0;
         pixels_left = '0;
         byte_idx = '0;
         accum = '0;
         emitted = '0;
         finished = 1'b0;
         expected_pixels.delete();
      end else begin
         // retire results before queuing new ones, so a result delivered in the same cycle as its byte is caught
         if (rsp_valid && !rsp_stall) check_pixel(rsp_item);
         if (req_valid && !req_stall) decode_byte(req_item);
         if (csr_write) begin
            case (csr_index)
               CSR_PIXEL_DEPTH:  depth_reg = depth_type'(csr_wdata[1:0]);
               CSR_IMAGE_PIXELS: pixel_total_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      error_count <= mismatches;
      pending_results <= expected_pixels.size();
      results_seen <= checked;
      pixels_decoded <= emitted;
   end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Feeds the RLE pixel decoder a compressed byte stream: short directed
// packets first (header extremes, count clamping, depth change inside a
// pixel), then random run and raw packets over all supported depths with
// register changes between packets, random idling on both sides and one long
// output hold-off. The run ends on one randomly picked way of finishing the
// image, followed by bytes that must be dropped.
// ----------------------------------------------------------------------------
module tb;
   import tga_rle_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          BYTE_TARGET = 1850;
   localparam int          IDLE_LIMIT  = 2000;
   localparam logic [31:0] PIXELS_MAX  = 32'd4294836225;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_item_type  req_item;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_item_type  rsp_item;
   logic          csr_write;
   csr_index_type csr_index;
   logic [31:0]   csr_wdata;

   int            error_count;
   int            pending_results;
   int            results_seen;
   logic [31:0]   pixels_decoded;

   int            items_sent = 0;
   int            stuck_cycles = 0;
   logic [31:0]   owed;
   depth_type     cur_depth;

   tga_rle_pixel_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tga_rle_decode_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending_results (pending_results),
      .results_seen    (results_seen),
      .pixels_decoded  (pixels_decoded)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 4) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic eod);
      // no gaps in the calm stretch of the stream
      if ((items_sent < 900 || items_sent >= 1200) && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= '{data_byte: b, end_of_data: eod};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // drop valid and let every owed result drain
   task automatic settle(input int tail);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_depth(input depth_type d);
      cur_depth = d;
      write_reg(CSR_PIXEL_DEPTH, 32'(d));
   endtask

   task automatic set_total(input logic [31:0] total);
      write_reg(CSR_IMAGE_PIXELS, total);
      owed = total - pixels_decoded;
   endtask

   task automatic reconfigure();
      int r;
      settle(4);
      set_depth(depth_type'($urandom_range(0, 2)));
      r = $urandom_range(0, 99);
      if (r < 15) set_total(pixels_decoded + 32'($urandom_range(1, 8)));
      else if (r < 30) set_total(PIXELS_MAX);
      else set_total(pixels_decoded + 32'($urandom_range(1000, 1000000)));
   endtask

   task automatic send_random_packet();
      logic [7:0] hdr;
      int         count;
      int         npix;
      int         r;
      r = $urandom_range(0, 99);
      if (r < 10)
         hdr = 8'($urandom_range(0, 255));
      else if (r < 55)
         hdr = RUN_FLAG_MASK | 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, 15));
      else
         hdr = 8'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7));
      count = (hdr & COUNT_FIELD_MASK) + 1;
      push_byte(hdr, 1'b0);
      // packet clamped to the pixels still owed: reopen the count before its pixels
      if (32'(count) >= owed) begin
         count = int'(owed);
         settle(4);
         set_total(pixels_decoded + 32'($urandom_range(1000, 1000000)));
      end
      owed = owed - 32'(count);
      npix = hdr[7] ? 1 : count;
      repeat (npix * (int'(cur_depth) + 2)) push_byte(pick_byte(), 1'b0);
   endtask

   // output side: random stalls, one calm stretch and one long hold-off
   initial begin
      int cyc;
      int hold_left;
      logic held;
      cyc = 0;
      hold_left = 0;
      held = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!held && items_sent >= 700) begin
            held = 1'b1;
            hold_left = 300;
            rsp_stall <= 1'b1;
         end else if (items_sent >= 900 && items_sent < 1200) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 7);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= IDLE_LIMIT) begin
         $display("tb: no progress for %0d cycles", IDLE_LIMIT);
         $display("tb: done, errors");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int         mode;
      int         k;
      int         n;
      int         bpp;
      logic [7:0] hdr;
      string      ending;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_PIXEL_DEPTH;
      csr_wdata <= '0;
      cur_depth = DEPTH_24;
      owed = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // longest run clamped to three 32-bit pixels
      set_depth(DEPTH_32);
      set_total(32'd3);
      push_byte(8'hFF, 1'b0);
      settle(4);
      set_total(PIXELS_MAX);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);

      // single raw 16-bit pixel, all ones
      settle(4);
      set_depth(DEPTH_16);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);

      // longest raw packet clamped to two 24-bit pixels, zero and all ones
      settle(4);
      set_depth(DEPTH_24);
      set_total(pixels_decoded + 32'd2);
      push_byte(8'h7F, 1'b0);
      settle(4);
      set_total(PIXELS_MAX);
      repeat (3) push_byte(8'h00, 1'b0);
      repeat (3) push_byte(8'hFF, 1'b0);

      // shrink the depth after two bytes of a 24-bit pixel
      push_byte(8'h80, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'hA5, 1'b0);
      settle(4);
      set_depth(DEPTH_16);
      push_byte(8'h3C, 1'b0);

      // full 128-pixel run
      settle(4);
      set_depth(DEPTH_32);
      push_byte(8'hFF, 1'b0);
      repeat (4) push_byte(pick_byte(), 1'b0);

      reconfigure();
      while (items_sent < BYTE_TARGET) begin
         send_random_packet();
         if ($urandom_range(0, 9) == 0) reconfigure();
      end

      settle(4);
      bpp = int'(cur_depth) + 2;
      mode = $urandom_range(0, 3);
      case (mode)
         0: begin
            ending = "short data";
            set_total(PIXELS_MAX);
            hdr = 8'($urandom_range(0, 255));
            n = $urandom_range(0, 2 * bpp);
            if (n == 0) begin
               push_byte(hdr, 1'b1);
            end else begin
               push_byte(hdr, 1'b0);
               repeat (n - 1) push_byte(pick_byte(), 1'b0);
               push_byte(pick_byte(), 1'b1);
            end
         end
         1: begin
            ending = "unsupported depth";
            set_depth(DEPTH_BAD);
            push_byte(pick_byte(), 1'($urandom_range(0, 1)));
         end
         2: begin
            ending = "image complete";
            k = $urandom_range(1, 3);
            set_total(pixels_decoded + 32'(k));
            hdr = ($urandom_range(0, 1) ? RUN_FLAG_MASK : 8'h00) |
                  8'($urandom_range(k - 1, 127));
            push_byte(hdr, 1'b0);
            n = (hdr[7] ? 1 : k) * bpp;
            repeat (n - 1) push_byte(pick_byte(), 1'b0);
            push_byte(pick_byte(), 1'($urandom_range(0, 1)));
         end
         default: begin
            ending = "count lowered";
            write_reg(CSR_IMAGE_PIXELS,
                      $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, pixels_decoded)));
            push_byte(pick_byte(), 1'($urandom_range(0, 1)));
         end
      endcase

      // decoder has finished: drop everything from here on
      repeat (20) push_byte(pick_byte(), 1'($urandom_range(0, 1)));
      settle(20);

      $display("tb: %0d bytes over 16/24/32-bit depths, clamped packets and mid-pixel depth change",
               items_sent);
      $display("tb: %0d results checked, stream ended by %s", results_seen, ending);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: %0d mismatches", error_count);
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
